// ===== rtl/core/hexu_pkg.sv =====
// Package for the hex escape unescaper: character codes, queue entry types
// and the hex digit decoder. No dependencies.
`timescale 1ns / 1ps

package hexu_pkg;

	localparam logic [7:0] BACKSLASH_CHAR = 8'h5C;
	localparam logic [7:0] X_CHAR         = 8'h78;

	localparam int CMD_DEPTH = 4;
	localparam int OUT_DEPTH = 2;

	// What the back part emits after the held characters
	localparam logic [1:0] TAIL_NONE = 2'd0;
	localparam logic [1:0] TAIL_CHAR = 2'd1;
	localparam logic [1:0] TAIL_TERM = 2'd2;

	// One command from front to back: held characters to flush, then a tail
	typedef struct packed {
		logic [1:0] held_n;
		logic [7:0] held_digit;
		logic [1:0] tail_kind;
		logic [7:0] tail_byte;
		logic       any;
	} cmd_t;

	typedef struct packed {
		logic [7:0] data;
		logic       is_data;
		logic       last;
		logic       any;
	} res_t;

	// {valid, nibble}
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [7:0] v;
		logic       ok;
		v  = 8'h00;
		ok = 1'b0;
		if (c >= 8'h30 && c <= 8'h39) begin
			v  = c - 8'h30;
			ok = 1'b1;
		end else if (c >= 8'h41 && c <= 8'h46) begin
			v  = c - 8'h37;
			ok = 1'b1;
		end else if (c >= 8'h61 && c <= 8'h66) begin
			v  = c - 8'h57;
			ok = 1'b1;
		end
		return {ok, v[3:0]};
	endfunction

endpackage

// ===== rtl/core/hex_escape_unescaper_top.sv =====
// Top level of the hex escape unescaper: front matcher, command queue,
// back expander and result queue. Depends on hexu_pkg and all hexu_ modules.
//
//   channel   handshake        fields
//   input     push / full      in_byte, end_marker
//   result    pop / empty      out_byte, is_data, last_of_string, any_decoded
//
// One request is taken per cycle while the command queue has room.
// The back expander emits one result per cycle while it holds a command and the
// result queue has room; a request yields up to four. A result is registered in
// the command queue and then in the result queue before it reaches the result ports.
// Reset clears all state and both queues; queue payload is not reset.
// A stalled result side fills the result queue, then the command queue,
// then raises full.
`timescale 1ns / 1ps

module hex_escape_unescaper_top #(
	parameter int CMD_DEPTH = hexu_pkg::CMD_DEPTH,
	parameter int OUT_DEPTH = hexu_pkg::OUT_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] in_byte,
	input  logic       end_marker,
	input  logic       pop,
	output logic       empty,
	output logic [7:0] out_byte,
	output logic       is_data,
	output logic       last_of_string,
	output logic       any_decoded
);

	localparam int CmdW = $bits(hexu_pkg::cmd_t);
	localparam int ResW = $bits(hexu_pkg::res_t);

	logic            cmd_full;
	logic            cmd_empty;
	logic            cmd_push;
	logic            cmd_pop;
	hexu_pkg::cmd_t  cmd_in;
	hexu_pkg::cmd_t  cmd_head;
	logic [CmdW-1:0] cmd_rdata;
	logic            out_full;
	logic            out_push;
	hexu_pkg::res_t  res_in;
	hexu_pkg::res_t  res_head;
	logic [ResW-1:0] res_rdata;

	assign full     = cmd_full;
	assign cmd_head = hexu_pkg::cmd_t'(cmd_rdata);
	assign res_head = hexu_pkg::res_t'(res_rdata);

	hexu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (push && !cmd_full),
		.in_byte   (in_byte),
		.end_marker(end_marker),
		.cmd_push  (cmd_push),
		.cmd       (cmd_in)
	);

	hexu_fifo #(
		.Width(CmdW),
		.Depth(CMD_DEPTH)
	) u_cmd_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (cmd_push),
		.wdata (cmd_in),
		.full  (cmd_full),
		.pop   (cmd_pop),
		.rdata (cmd_rdata),
		.empty (cmd_empty)
	);

	hexu_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_empty(cmd_empty),
		.cmd      (cmd_head),
		.cmd_pop  (cmd_pop),
		.out_full (out_full),
		.out_push (out_push),
		.res      (res_in)
	);

	hexu_fifo #(
		.Width(ResW),
		.Depth(OUT_DEPTH)
	) u_out_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (out_push),
		.wdata (res_in),
		.full  (out_full),
		.pop   (pop),
		.rdata (res_rdata),
		.empty (empty)
	);

	assign out_byte       = res_head.data;
	assign is_data        = res_head.is_data;
	assign last_of_string = res_head.last;
	assign any_decoded    = res_head.any;

endmodule

// ===== rtl/core/hexu_fifo.sv =====
// Small first-in first-out queue built from registers.
// Generic; no package dependency.
`timescale 1ns / 1ps

module hexu_fifo #(
	parameter int Width = 8,
	parameter int Depth = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [Width-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [Width-1:0] rdata,
	output logic             empty
);

	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CW = $clog2(Depth + 1);

	logic [Width-1:0] mem_q [Depth];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(Depth));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// ===== rtl/core/hexu_front.sv =====
// Front part: escape matcher. Holds partial escapes and issues one command
// per request that produces output. Depends on hexu_pkg.
`timescale 1ns / 1ps

module hexu_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [7:0]       in_byte,
	input  logic             end_marker,
	output logic             cmd_push,
	output hexu_pkg::cmd_t   cmd
);

	logic [1:0] held_q;
	logic [7:0] digit_q;
	logic       seen_q;
	logic [1:0] held_d;
	logic [7:0] digit_d;
	logic       seen_d;
	logic [4:0] hi_hex;
	logic [4:0] lo_hex;

	assign hi_hex = hexu_pkg::hex_decode(digit_q);
	assign lo_hex = hexu_pkg::hex_decode(in_byte);

	always_comb begin
		logic fail;
		logic is_bs;
		fail           = 1'b0;
		is_bs          = (in_byte == hexu_pkg::BACKSLASH_CHAR);
		held_d         = held_q;
		digit_d        = digit_q;
		seen_d         = seen_q;
		cmd_push       = 1'b0;
		cmd.held_n     = 2'd0;
		cmd.held_digit = digit_q;
		cmd.tail_kind  = hexu_pkg::TAIL_CHAR;
		cmd.tail_byte  = in_byte;
		cmd.any        = 1'b0;
		if (in_valid) begin
			if (end_marker) begin
				cmd_push      = 1'b1;
				cmd.held_n    = held_q;
				cmd.tail_kind = hexu_pkg::TAIL_TERM;
				cmd.tail_byte = 8'h00;
				cmd.any       = seen_q;
				held_d        = 2'd0;
				seen_d        = 1'b0;
			end else begin
				case (held_q)
					2'd0: begin
						if (is_bs) begin
							held_d = 2'd1;
						end else begin
							cmd_push = 1'b1;
						end
					end
					2'd1: begin
						if (in_byte == hexu_pkg::X_CHAR) begin
							held_d = 2'd2;
						end else begin
							fail = 1'b1;
						end
					end
					2'd2: begin
						if (lo_hex[4]) begin
							digit_d = in_byte;
							held_d  = 2'd3;
						end else begin
							fail = 1'b1;
						end
					end
					default: begin
						// \x00 is left as plain text
						if (hi_hex[4] && lo_hex[4] && (hi_hex[3:0] | lo_hex[3:0]) != 4'h0) begin
							cmd_push      = 1'b1;
							cmd.tail_byte = {hi_hex[3:0], lo_hex[3:0]};
							seen_d        = 1'b1;
							held_d        = 2'd0;
						end else begin
							fail = 1'b1;
						end
					end
				endcase
				if (fail) begin
					// flush what is held, then rescan this char from idle
					cmd_push      = 1'b1;
					cmd.held_n    = held_q;
					cmd.tail_kind = is_bs ? hexu_pkg::TAIL_NONE : hexu_pkg::TAIL_CHAR;
					held_d        = is_bs ? 2'd1 : 2'd0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q  <= 2'd0;
			digit_q <= 8'h00;
			seen_q  <= 1'b0;
		end else begin
			held_q  <= held_d;
			digit_q <= digit_d;
			seen_q  <= seen_d;
		end
	end

`ifndef SYNTHESIS
	a_digit_is_hex: assert property (@(posedge clk) disable iff (!arst_n)
		held_q == 2'd3 |-> hi_hex[4])
		else $error("held digit is not a hex digit");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && end_marker |=> held_q == 2'd0 && !seen_q)
		else $error("end of string left state behind");

	a_cmd_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push && cmd.tail_kind == hexu_pkg::TAIL_NONE |-> cmd.held_n != 2'd0)
		else $error("command with nothing to emit");
`endif

endmodule

// ===== rtl/core/hexu_back.sv =====
// Back part: expands one command into its results, one per cycle while the
// result queue has room. Depends on hexu_pkg.
`timescale 1ns / 1ps

module hexu_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_empty,
	input  hexu_pkg::cmd_t   cmd,
	output logic             cmd_pop,
	input  logic             out_full,
	output logic             out_push,
	output hexu_pkg::res_t   res
);

	logic [1:0] pos_q;
	logic [1:0] last_idx;
	logic       step;

	assign last_idx = (cmd.tail_kind == hexu_pkg::TAIL_NONE) ? cmd.held_n - 2'd1 : cmd.held_n;
	assign step     = !cmd_empty && !out_full;
	assign out_push = step;
	assign cmd_pop  = step && (pos_q == last_idx);

	always_comb begin
		res.data    = 8'h00;
		res.is_data = 1'b1;
		res.last    = 1'b0;
		res.any     = 1'b0;
		if (pos_q < cmd.held_n) begin
			case (pos_q)
				2'd0:    res.data = hexu_pkg::BACKSLASH_CHAR;
				2'd1:    res.data = hexu_pkg::X_CHAR;
				default: res.data = cmd.held_digit;
			endcase
		end else begin
			case (cmd.tail_kind)
				hexu_pkg::TAIL_TERM: begin
					res.is_data = 1'b0;
					res.last    = 1'b1;
					res.any     = cmd.any;
				end
				default: res.data = cmd.tail_byte;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 2'd0;
		end else if (step) begin
			pos_q <= cmd_pop ? 2'd0 : pos_q + 2'd1;
		end
	end

`ifndef SYNTHESIS
	a_head_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd_empty |-> !(cmd.held_n == 2'd0 && cmd.tail_kind == hexu_pkg::TAIL_NONE))
		else $error("empty command at queue head");

	a_mid_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q != 2'd0 |-> !cmd_empty)
		else $error("command lost mid expansion");

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q != 2'd0 |-> pos_q <= last_idx)
		else $error("expansion ran past command end");
`endif

endmodule
